### hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/plst_pkg.sv
// constants, codes and interface types of the positional list store
// used by every module of the block; no dependencies
package plst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_FUNC_LSB   = 0;
   localparam int REQ_VALUE_LSB  = REQ_FUNC_LSB + FUNC_W;
   localparam int REQ_POS_LSB    = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_DATA_W     = 48;

   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_ELEM_LSB   = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_COUNT_LSB  = RSP_ELEM_LSB + VALUE_W;
   localparam int RSP_USED_W     = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_DATA_W     = 40;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INS_FRONT = 3'd0,
      FUNC_INS_BACK  = 3'd1,
      FUNC_DEL_FRONT = 3'd2,
      FUNC_DEL_BACK  = 3'd3,
      FUNC_INS_AT    = 3'd4,
      FUNC_DEL_AT    = 3'd5,
      FUNC_DUMP      = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic                      we;
      logic [IDX_W-1:0]          waddr;
      logic signed [VALUE_W-1:0] wdata;
      logic [IDX_W-1:0]          raddr;
   } mem_req_type;

   typedef struct packed {
      logic                      load;
      status_type                status;
      logic signed [VALUE_W-1:0] element;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } rsp_load_type;

endpackage

### hdl/positional_list_store_unit.sv
// Ordered list of up to 16 signed 32-bit values held in a synchronous memory.
// req channel: one item per operation (insert front/back/at position, delete
// front/back/at position, dump). rsp channel: result items with status,
// element and element count; tlast marks the final result of an operation.
// An item is taken only while the sequencer is idle, i.e. one operation at a
// time. A failed op, the spare code, an empty dump and a delete of the last
// entry load their result from the response state; an insert at the back end
// first writes its value in the fill state. An op that moves k entries
// (positional insert/delete, front insert, front delete) uses one memory read
// per moved entry in the shift state, k up to 15, then passes the drain state
// and, for an insert, the fill state before the response state. A dump of n
// entries loads one result per cycle while rsp is not stalled, the last with
// tlast. The next item can be taken in the cycle after the load.
// The result sits in an output register, so the next item can be accepted
// while it waits to be taken. A stall on rsp holds that register and, during
// a dump, pauses the memory walk without loss.
// Reset empties the list at once (count cleared); no clearing pass is run and
// memory contents beyond the count are never returned.
// depends on plst_pkg, plst_ctrl and plst_mem
module positional_list_store_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // func[2:0], value[34:3], position[40:35], zero fill
   input  logic [plst_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status[1:0], element[33:2], element_count[38:34], zero fill
   output logic [plst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import plst_pkg::*;

   mem_req_type               mem_req;
   rsp_load_type              rsp_load;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      out_free;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_element_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   plst_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_func     (req_tdata[REQ_FUNC_LSB +: FUNC_W]),
      .req_value    (req_tdata[REQ_VALUE_LSB +: VALUE_W]),
      .req_position (req_tdata[REQ_POS_LSB +: POS_W]),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .mem_req      (mem_req),
      .rsp_load     (rsp_load)
   );

   plst_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rsp_status_ff  <= rsp_load.status;
         rsp_element_ff <= rsp_load.element;
         rsp_count_ff   <= rsp_load.count;
         rsp_last_ff    <= rsp_load.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, rsp_count_ff,
                        rsp_element_ff, rsp_status_ff};

endmodule

### hdl/plst_mem.sv
// entry memory: one write port, one read port with registered read data
// depends on plst_pkg
module plst_mem (
   input  logic                               clock,
   input  plst_pkg::mem_req_type              mem_req,
   output logic signed [plst_pkg::VALUE_W-1:0] rd_data
);
   import plst_pkg::*;

   logic signed [VALUE_W-1:0] store_ff [CAPACITY];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= store_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/plst_ctrl.sv
// sequencer: decodes an item, shifts entries through the memory, streams dumps
// depends on plst_pkg and drives plst_mem
module plst_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [plst_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [plst_pkg::VALUE_W-1:0] req_value,
   input  logic [plst_pkg::POS_W-1:0]          req_position,
   input  logic                                out_free,
   input  logic signed [plst_pkg::VALUE_W-1:0] rd_data,
   output plst_pkg::mem_req_type               mem_req,
   output plst_pkg::rsp_load_type              rsp_load
);
   import plst_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SHIFT = 6'b000010,
      S_DRAIN = 6'b000100,
      S_FILL  = 6'b001000,
      S_DUMP  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]          src_ff, src_in;
   logic [IDX_W-1:0]          end_ff, end_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;
   logic                      up_ff, up_in;
   logic                      wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]          wr_addr_ff, wr_addr_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic                      have_ff, have_in;

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] tot_w;
   logic             is_full;
   logic             is_empty;
   logic             do_ins;
   logic             do_del;
   logic [IDX_W-1:0] op_idx;
   logic             emit;
   logic             dump_last;

   assign pos_w     = CMP_W'(req_position);
   assign tot_w     = CMP_W'(total_ff);
   assign is_full   = (total_ff >= CNT_W'(CAPACITY));
   assign is_empty  = (total_ff == '0);
   assign emit      = (state_ff == S_DUMP) && have_ff && out_free;
   assign dump_last = ((CNT_W'(ptr_ff) + CNT_W'(1)) == total_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      src_in     = src_ff;
      end_in     = end_ff;
      slot_in    = slot_ff;
      up_in      = up_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      ptr_in     = ptr_ff;
      have_in    = have_ff;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      op_idx     = '0;

      mem_req.we    = wr_pend_ff;
      mem_req.waddr = wr_addr_ff;
      mem_req.wdata = rd_data;
      mem_req.raddr = src_ff;

      rsp_load.load    = 1'b0;
      rsp_load.status  = status_ff;
      rsp_load.element = '0;
      rsp_load.count   = tot_w[COUNT_W-1:0];
      rsp_load.last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req_func)
                  FUNC_INS_FRONT, FUNC_INS_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        do_ins = 1'b1;
                        op_idx = (req_func == FUNC_INS_FRONT) ? '0 : IDX_W'(total_ff);
                     end
                  end
                  FUNC_INS_AT: begin
                     if (pos_w == '0 || pos_w > tot_w + CMP_W'(1)) begin
                        status_in = ST_BADPOS;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        do_ins = 1'b1;
                        op_idx = IDX_W'(req_position - POS_W'(1));
                     end
                  end
                  FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        do_del = 1'b1;
                        op_idx = (req_func == FUNC_DEL_FRONT) ? '0
                                 : IDX_W'(total_ff - CNT_W'(1));
                     end
                  end
                  FUNC_DEL_AT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_w == '0 || pos_w > tot_w) begin
                        status_in = ST_BADPOS;
                     end else begin
                        do_del = 1'b1;
                        op_idx = IDX_W'(req_position - POS_W'(1));
                     end
                  end
                  FUNC_DUMP: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        ptr_in   = '0;
                        have_in  = 1'b0;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase

               // inserts open a gap from the back end down to the slot
               if (do_ins) begin
                  total_in = total_ff + CNT_W'(1);
                  value_in = req_value;
                  slot_in  = op_idx;
                  if (CNT_W'(op_idx) == total_ff) begin
                     state_in = S_FILL;
                  end else begin
                     up_in    = 1'b1;
                     src_in   = IDX_W'(total_ff - CNT_W'(1));
                     end_in   = op_idx;
                     state_in = S_SHIFT;
                  end
               end

               // deletes close the gap from the slot up to the back end
               if (do_del) begin
                  total_in = total_ff - CNT_W'(1);
                  if (CNT_W'(op_idx) + CNT_W'(1) == total_ff) begin
                     state_in = S_RESP;
                  end else begin
                     up_in    = 1'b0;
                     src_in   = op_idx + IDX_W'(1);
                     end_in   = IDX_W'(total_ff - CNT_W'(1));
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_SHIFT: begin
            // read one entry, write it one slot over in the next cycle
            wr_pend_in = 1'b1;
            wr_addr_in = up_ff ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
            if (src_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = up_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = up_ff ? S_FILL : S_RESP;
         end
         S_FILL: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_ff;
            mem_req.wdata = value_ff;
            state_in      = S_RESP;
         end
         S_DUMP: begin
            // read address runs one ahead so each emitted item is followed at once
            mem_req.raddr    = emit ? ptr_ff + IDX_W'(1) : ptr_ff;
            have_in          = 1'b1;
            rsp_load.load    = emit;
            rsp_load.status  = ST_OK;
            rsp_load.element = rd_data;
            rsp_load.last    = dump_last;
            if (emit) begin
               ptr_in = ptr_ff + IDX_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESP: begin
            rsp_load.load = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         wr_pend_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         wr_pend_ff <= wr_pend_in;
         have_ff    <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      value_ff   <= value_in;
      src_ff     <= src_in;
      end_ff     <= end_in;
      slot_ff    <= slot_in;
      up_ff      <= up_in;
      wr_addr_ff <= wr_addr_in;
      ptr_ff     <= ptr_in;
   end

endmodule

### hdl/plst_checker.sv
// port-level checks on the result channel of positional_list_store_unit
// depends on plst_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module plst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [plst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import plst_pkg::*;

   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_element;
   logic [COUNT_W-1:0]  rsp_count;

   assign rsp_status  = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
   assign rsp_element = rsp_tdata[RSP_ELEM_LSB +: VALUE_W];
   assign rsp_count   = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];

   `ASSERT_PROP(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "rsp item changed while stalled")

   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "rsp item shown right after reset")

   `ASSERT_PROP(a_count_bound, clock, reset, rsp_tvalid |-> (int'(rsp_count) <= CAPACITY), "element count above capacity")

   `ASSERT_PROP(a_fail_single, clock, reset, (rsp_tvalid && rsp_status != ST_OK) |-> (rsp_tlast && rsp_element == '0), "failed operation gave a non-final or nonzero item")

   `ASSERT_PROP(a_dump_count, clock, reset, (rsp_tvalid && !rsp_tlast) |-> (rsp_status == ST_OK && rsp_count != '0), "dump item from an empty list or with bad status")

endmodule

bind positional_list_store_unit plst_checker u_plst_checker (.*);

### test/testbench.sv
// self-checking bench for positional_list_store_unit: drives list operations on req,
// tracks the list in a queue and compares every rsp item with the predicted one
// depends on plst_pkg and the block's RTL
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import plst_pkg::*;

   // func code outside the enum: the block answers ok and changes nothing
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] element;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } list_result_type;

   class list_tracker;
      logic signed [VALUE_W-1:0] entries[$];
      list_result_type           pending_results[$];
      int                        mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int size();
         return entries.size();
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void push_result(status_type st, logic signed [VALUE_W-1:0] el, logic fin);
         list_result_type r;
         r.status  = st;
         r.element = el;
         r.count   = COUNT_W'(entries.size());
         r.last    = fin;
         pending_results.push_back(r);
      endfunction

      // apply one accepted operation to the list and queue the results it causes
      function void apply_op(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                             logic [POS_W-1:0] p);
         int         n;
         int         ip;
         status_type st;
         n  = entries.size();
         ip = int'(p);
         st = ST_OK;
         case (f)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
               if (n >= CAPACITY) st = ST_FULL;
               else if (f == FUNC_INS_FRONT) entries.push_front(v);
               else entries.push_back(v);
            end
            FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
               if (n == 0) st = ST_EMPTY;
               else if (f == FUNC_DEL_FRONT) void'(entries.pop_front());
               else void'(entries.pop_back());
            end
            FUNC_INS_AT: begin
               if (ip < 1 || ip > n + 1) st = ST_BADPOS;
               else if (n >= CAPACITY) st = ST_FULL;
               else entries.insert(ip - 1, v);
            end
            FUNC_DEL_AT: begin
               if (n == 0) st = ST_EMPTY;
               else if (ip < 1 || ip > n) st = ST_BADPOS;
               else entries.delete(ip - 1);
            end
            FUNC_DUMP: begin
               if (n == 0) push_result(ST_EMPTY, '0, 1'b1);
               else foreach (entries[i]) push_result(ST_OK, entries[i], i == n - 1);
               return;
            end
            default: ;
         endcase
         push_result(st, '0, 1'b1);
      endfunction

      function void compare_result(logic [RSP_DATA_W-1:0] data, logic got_last);
         list_result_type           want;
         logic [STATUS_W-1:0]       got_status;
         logic signed [VALUE_W-1:0] got_elem;
         logic [COUNT_W-1:0]        got_count;
         got_status = data[RSP_STATUS_LSB +: STATUS_W];
         got_elem   = data[RSP_ELEM_LSB +: VALUE_W];
         got_count  = data[RSP_COUNT_LSB +: COUNT_W];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item: status %0d element %0d count %0d last %0b",
                        $time, got_status, got_elem, got_count, got_last);
            return;
         end
         want = pending_results.pop_front();
         if (got_status !== want.status || got_elem !== want.element ||
             got_count !== want.count || got_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: expected status %0d element %0d count %0d last %0b, got status %0d element %0d count %0d last %0b",
                        $time, want.status, want.element, want.count, want.last,
                        got_status, got_elem, got_count, got_last);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int          send_idle_pct = 38;
   int          recv_idle_pct = 53;
   int          quiet_cycles  = 0;
   list_tracker tracker       = new();

   positional_list_store_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: check what was taken at this edge, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.compare_result(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles in which neither channel moved an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // present one item, hold it until taken; valid stays high into the next call
   task automatic send_op(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                          logic [POS_W-1:0] p);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[REQ_FUNC_LSB +: FUNC_W]   = f;
      word[REQ_VALUE_LSB +: VALUE_W] = v;
      word[REQ_POS_LSB +: POS_W]     = p;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.apply_op(f, v, p);
   endtask

   task automatic directed_ops();
      int k;
      send_op(FUNC_DUMP, 32'sd5, 6'd0);
      send_op(FUNC_DEL_FRONT, 32'sd0, 6'd0);
      send_op(FUNC_DEL_BACK, 32'sd0, 6'd0);
      send_op(FUNC_DEL_AT, 32'sd0, 6'd1);
      send_op(FUNC_INS_AT, 32'sd1, 6'd0);
      send_op(FUNC_INS_AT, 32'sd1, 6'd2);
      send_op(FUNC_SPARE, 32'sd9, 6'd63);
      // position 1 and count+1 behave as front and back inserts
      send_op(FUNC_INS_AT, 32'sh7fffffff, 6'd1);
      send_op(FUNC_INS_AT, 32'sh80000000, 6'd2);
      send_op(FUNC_DEL_AT, 32'sd0, 6'd0);
      send_op(FUNC_DUMP, 32'sd0, 6'd0);
      k = 0;
      while (tracker.size() < CAPACITY) begin
         send_op(k[0] ? FUNC_INS_FRONT : FUNC_INS_BACK, $urandom(), 6'($urandom()));
         k++;
      end
      send_op(FUNC_INS_FRONT, 32'sd1, 6'd0);
      send_op(FUNC_INS_BACK, 32'sd2, 6'd0);
      send_op(FUNC_INS_AT, 32'sd3, 6'd17);
      send_op(FUNC_INS_AT, 32'sd4, 6'd63);
      send_op(FUNC_DUMP, 32'sd0, 6'd0);
      send_op(FUNC_DEL_AT, 32'sd0, 6'd63);
      send_op(FUNC_DEL_AT, 32'sd0, 6'd16);
      send_op(FUNC_DEL_AT, 32'sd0, 6'd5);
   endtask

   // random walk that swings the list between empty and full
   task automatic random_ops(int n);
      int                        cnt;
      int                        roll;
      bit                        growing;
      logic [FUNC_W-1:0]         f;
      logic signed [VALUE_W-1:0] v;
      logic [POS_W-1:0]          p;
      growing = 1'b1;
      for (int k = 0; k < n; k++) begin
         cnt = tracker.size();
         if (cnt >= CAPACITY) growing = 1'b0;
         else if (cnt == 0) growing = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            f = FUNC_DUMP;
         end else if (roll < 8) begin
            f = FUNC_SPARE;
         end else if (roll < (growing ? 76 : 32)) begin
            case ($urandom_range(0, 2))
               0:       f = FUNC_INS_FRONT;
               1:       f = FUNC_INS_BACK;
               default: f = FUNC_INS_AT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       f = FUNC_DEL_FRONT;
               1:       f = FUNC_DEL_BACK;
               default: f = FUNC_DEL_AT;
            endcase
         end
         case ($urandom_range(0, 9))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = 32'sd0;
            3:       v = -32'sd1;
            default: v = $urandom();
         endcase
         if ($urandom_range(0, 99) < 15) p = 6'($urandom_range(0, 63));
         else if (f == FUNC_INS_AT) p = 6'($urandom_range(1, cnt + 1));
         else p = 6'($urandom_range(1, (cnt > 0) ? cnt : 1));
         send_op(f, v, p);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 53;
      directed_ops();
      random_ops(42);

      send_idle_pct = 53;
      recv_idle_pct = 38;
      random_ops(42);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_ops(43);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
